FILE: design/bvcp_pkg.sv
package bvcp_pkg;

    localparam int VoltW     = 13;
    localparam int PctW      = 7;
    localparam int OffW      = 10;
    localparam int TableSlots = 32;
    localparam int DenW      = 8;   // widest segment is 230 mV
    localparam int StepW     = 3;   // percent change per segment, at most MaxStep
    localparam int MaxStep   = 5;
    localparam int TermW     = 12;  // 2*num + den, at most 2530

    localparam logic [VoltW-1:0] VoltMax   = 13'd8191;
    localparam logic [OffW-1:0]  OffsetRst = 10'd130;
    localparam logic [PctW-1:0]  PctFull   = 7'd100;
    localparam logic [PctW-1:0]  PctEmpty  = 7'd1;

    localparam logic [VoltW-1:0] BP_MV [TableSlots] = '{
        13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950, 13'd3910,
        13'd3870, 13'd3850, 13'd3840, 13'd3820, 13'd3800, 13'd3790, 13'd3770, 13'd3750,
        13'd3730, 13'd3690, 13'd3610, 13'd3500, 13'd3270, 13'd3270, 13'd3270, 13'd3270,
        13'd3270, 13'd3270, 13'd3270, 13'd3270, 13'd3270, 13'd3270, 13'd3270, 13'd3270
    };

    localparam logic [PctW-1:0] BP_PCT [TableSlots] = '{
        7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65,
        7'd60,  7'd55, 7'd50, 7'd45, 7'd40, 7'd35, 7'd30, 7'd25,
        7'd20,  7'd15, 7'd10, 7'd5,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd0,   7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
    };

    typedef struct packed {
        logic full;
        logic empty;
    } range_t;

endpackage

FILE: design/battery_voltage_to_charge_percent.sv
// Battery voltage to state-of-charge converter.
//
// Input stream: s_tvalid/s_tready/s_tdata, one beat per sample, voltage in
// mV in s_tdata[12:0]. Output stream: m_tvalid/m_tready/m_tdata, one beat per
// sample, charge in percent (1..100) in m_tdata[6:0], in input order.
// Config: cfg_valid/cfg_ready/cfg_data write the signed mV offset added to
// each sample; cfg_ready is always high. Write only while the pipe is empty.
//
// Five register stages: offset add and saturate, segment compare, segment
// select, multiply, quotient compare into the output register. m_tvalid
// rises when the beat reaches the output register; throughput is one beat
// per cycle while m_tready does not hold the pipe.
// All stages move together: while m_tvalid is high and m_tready low the
// whole pipe holds and s_tready drops, nothing is lost or repeated.
// Reset empties the pipe and loads an offset of 130 mV.
module battery_voltage_to_charge_percent
    import bvcp_pkg::*;
#(
    parameter int BREAKPOINTS = 21
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,    // [12:0] voltage_mv
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,    // [6:0] charge_percent
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [OffW-1:0] cfg_data    // offset_mv, signed
);

    localparam int Stages = 5;

    logic            adv;
    logic [OffW-1:0] offset_reg;
    logic [Stages-1:0] vld_reg, vld_next;

    assign adv       = !vld_reg[Stages-1] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OffsetRst;
        end
        else if (cfg_valid)
        begin
            offset_reg <= cfg_data;
        end
    end

    assign vld_next = {vld_reg[Stages-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: offset and saturate
    logic signed [VoltW+1:0] vsum;
    logic [VoltW-1:0]        v1_next, v1_reg;

    assign vsum = $signed({2'b00, s_tdata[VoltW-1:0]}) + (VoltW+2)'($signed(offset_reg));

    always_comb
    begin
        if (vsum < 0)
        begin
            v1_next = '0;
        end
        else if (vsum > $signed({2'b00, VoltMax}))
        begin
            v1_next = VoltMax;
        end
        else
        begin
            v1_next = vsum[VoltW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_reg <= v1_next;
        end
    end

    logic [PctW-1:0] pct;

    bvcp_core #(
        .BREAKPOINTS(BREAKPOINTS)
    ) u_core (
        .clk (clk),
        .en  (adv),
        .v_in(v1_reg),
        .pct (pct)
    );

    assign m_tvalid = vld_reg[Stages-1];
    assign m_tdata  = {1'b0, pct};

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pct >= PctEmpty && pct <= PctFull))
        else $error("charge out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipe moved during stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted beat not in first stage");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> offset_reg == $past(cfg_data))
        else $error("offset write lost");

endmodule

FILE: design/bvcp_core.sv
module bvcp_core
    import bvcp_pkg::*;
#(
    parameter int BREAKPOINTS = 21
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [VoltW-1:0] v_in,
    output logic [PctW-1:0]  pct
);

    localparam int NSeg = BREAKPOINTS - 1;

    // stage 2: segment hit mask
    logic [NSeg-1:0]  hit_next;
    logic [NSeg-1:0]  hit_reg;
    logic [VoltW-1:0] v2_reg;
    range_t           rng_next;
    range_t           rng2_reg;

    always_comb
    begin
        for (int i = 0; i < NSeg; i++)
        begin
            hit_next[i] = (BP_MV[i] > BP_MV[i+1]) && (v_in >= BP_MV[i+1]) && (v_in <= BP_MV[i]);
        end
        rng_next.full  = (v_in >= BP_MV[0]);
        rng_next.empty = (v_in <= BP_MV[NSeg]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            v2_reg   <= v_in;
            rng2_reg <= rng_next;
        end
    end

    // stage 3: pick the highest-voltage hit
    logic [DenW-1:0]  diff_next, den_next;
    logic [StepW-1:0] step_next;
    logic [PctW-1:0]  base_next;
    logic             found;
    logic [VoltW-1:0] hi_dif, span;
    logic [DenW-1:0]  diff_reg, den3_reg;
    logic [StepW-1:0] step_reg;
    logic [PctW-1:0]  base3_reg;
    range_t           rng_sel, rng3_reg;

    always_comb
    begin
        diff_next = '0;
        den_next  = '0;
        step_next = '0;
        base_next = '0;
        found     = 1'b0;
        hi_dif    = '0;
        span      = '0;
        for (int i = NSeg - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                found     = 1'b1;
                hi_dif    = v2_reg - BP_MV[i+1];
                span      = BP_MV[i] - BP_MV[i+1];
                step_next = StepW'(BP_PCT[i] - BP_PCT[i+1]);
                base_next = BP_PCT[i+1];
            end
        end
        diff_next     = hi_dif[DenW-1:0];
        den_next      = span[DenW-1:0];
        rng_sel.full  = rng2_reg.full;
        rng_sel.empty = rng2_reg.empty || !found;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg  <= diff_next;
            den3_reg  <= den_next;
            step_reg  <= step_next;
            base3_reg <= base_next;
            rng3_reg  <= rng_sel;
        end
    end

    // stage 4: 2*num + den
    logic [TermW-1:0] num;
    logic [TermW-1:0] term_reg;
    logic [DenW-1:0]  den4_reg;
    logic [PctW-1:0]  base4_reg;
    range_t           rng4_reg;

    assign num = TermW'(diff_reg) * TermW'(step_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg  <= {num[TermW-2:0], 1'b0} + TermW'(den3_reg);
            den4_reg  <= den3_reg;
            base4_reg <= base3_reg;
            rng4_reg  <= rng3_reg;
        end
    end

    // stage 5: quotient by compare against multiples of 2*den
    logic [StepW-1:0] quo;
    logic [PctW-1:0]  sum;
    logic [PctW-1:0]  pct_next;
    logic [PctW-1:0]  pct_reg;

    always_comb
    begin
        quo = '0;
        for (int k = 1; k <= MaxStep; k++)
        begin
            if (term_reg >= TermW'(TermW'(den4_reg) * TermW'(2 * k)))
            begin
                quo = quo + StepW'(1);
            end
        end
        sum = base4_reg + PctW'(quo);
        if (rng4_reg.full)
        begin
            pct_next = PctFull;
        end
        else if (rng4_reg.empty || sum < PctEmpty)
        begin
            pct_next = PctEmpty;
        end
        else
        begin
            pct_next = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pct_reg <= pct_next;
        end
    end

    assign pct = pct_reg;

endmodule
